[src/assert_macros.svh]
// assertion macros for the heatmap pixel unit
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SGHM_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("heatmap unit assertion failed");

// next-cycle implication
`define SGHM_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("heatmap unit assertion failed");

`endif

[src/sghm_pkg.sv]
// shared constants and types for the segment gaussian heatmap pixel unit
// no dependencies
package sghm_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int CFG_ADDR_BITS  = 5;
	localparam int PEAK_BITS      = 16;
	localparam int DECAY_BITS     = 24;
	localparam int TAYLOR_TERMS   = 12;
	localparam int SQUARINGS      = 5;
	localparam int T_LIMIT_INT    = 17;

	localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
	localparam logic [31:0] HALF_Q31 = 32'h4000_0000;

	// register indexes
	localparam logic [2:0] REG_SEG_START_X = 3'd0;
	localparam logic [2:0] REG_SEG_START_Y = 3'd1;
	localparam logic [2:0] REG_SEG_END_X   = 3'd2;
	localparam logic [2:0] REG_SEG_END_Y   = 3'd3;
	localparam logic [2:0] REG_PEAK_LEVEL  = 3'd4;
	localparam logic [2:0] REG_DECAY_RATE  = 3'd5;

	// commands
	localparam logic CMD_ACCUM    = 1'b0;
	localparam logic CMD_FINALIZE = 1'b1;

	// floor((2^32-1)/k) for k = 1..12, reciprocal for the series divides
	localparam logic [31:0] RECIP_Q32 [TAYLOR_TERMS] = '{
		32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
		32'd858993459,  32'd715827882,  32'd613566756,  32'd536870911,
		32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941
	};

	// payload that rides along the whole pipe
	typedef struct packed {
		logic        cmd;
		logic [15:0] prior;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
	} side_t;

endpackage

[src/segment_gaussian_heatmap_pixel_unit.sv]
// segment gaussian heatmap pixel unit, top level
// depends on sghm_pkg and assert_macros.svh
//
// throughput: one item per cycle; the whole pipe holds while a result is stalled
// depth is set by the pipelined restoring divider and the 12-term series (3 stages per term)
// reset: arst_n clears the configuration registers and all valid bits, no clearing pass
`include "assert_macros.svh"

module segment_gaussian_heatmap_pixel_unit #(
	parameter int COORD_BITS = sghm_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sghm_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// input items
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               command,
	input  logic [COORD_BITS-1:0]              pixel_col,
	input  logic [COORD_BITS-1:0]              pixel_row,
	input  logic [15:0]                        prior_value,
	input  logic [7:0]                         blue_in,
	input  logic [7:0]                         green_in,
	input  logic [7:0]                         red_in,
	// result items
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [15:0]                        new_value,
	output logic [7:0]                         blue_out,
	output logic [7:0]                         green_out,
	output logic [7:0]                         red_out
);

	localparam int CW   = COORD_BITS;
	localparam int SW   = CW + 1;          // signed coordinate difference
	localparam int PW   = 2 * CW + 2;      // signed products
	localparam int DSW  = 2 * CW + 1;      // squared lengths
	localparam int C2W  = 4 * CW + 2;      // cross squared
	localparam int NW   = C2W + 8;         // dividend with 8 fraction bits
	localparam int QB   = 2 * CW + 9;      // quotient bits, squared distance in Q.8
	localparam int TW   = sghm_pkg::DECAY_BITS + QB;
	localparam int NT   = sghm_pkg::TAYLOR_TERMS;
	localparam int NSQ  = sghm_pkg::SQUARINGS;
	localparam int NST  = QB + 50;
	localparam int DIVV = QB + 3;          // valid bit index at divider end
	localparam int SQV  = QB + 47;         // valid bit index at squaring end
	localparam logic [TW-1:0] T_LIMIT = TW'(sghm_pkg::T_LIMIT_INT) << 32;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [CW-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [15:0]   peak_q;
	logic [23:0]   decay_q;
	logic [2:0]    reg_idx;

	assign reg_idx = paddr[sghm_pkg::CFG_ADDR_BITS-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q    <= '0;
			sy_q    <= '0;
			ex_q    <= '0;
			ey_q    <= '0;
			peak_q  <= '0;
			decay_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				sghm_pkg::REG_SEG_START_X: sx_q    <= pwdata[CW-1:0];
				sghm_pkg::REG_SEG_START_Y: sy_q    <= pwdata[CW-1:0];
				sghm_pkg::REG_SEG_END_X:   ex_q    <= pwdata[CW-1:0];
				sghm_pkg::REG_SEG_END_Y:   ey_q    <= pwdata[CW-1:0];
				sghm_pkg::REG_PEAK_LEVEL:  peak_q  <= pwdata[15:0];
				sghm_pkg::REG_DECAY_RATE:  decay_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sghm_pkg::REG_SEG_START_X: prdata = 32'(sx_q);
			sghm_pkg::REG_SEG_START_Y: prdata = 32'(sy_q);
			sghm_pkg::REG_SEG_END_X:   prdata = 32'(ex_q);
			sghm_pkg::REG_SEG_END_Y:   prdata = 32'(ey_q);
			sghm_pkg::REG_PEAK_LEVEL:  prdata = 32'(peak_q);
			sghm_pkg::REG_DECAY_RATE:  prdata = 32'(decay_q);
			default:                   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// pipe control: every stage moves together, the last stage is the
	// output register
	// ------------------------------------------------------------------
	logic           adv;
	logic [NST-1:0] valid_s;
	sghm_pkg::side_t side_in;
	sghm_pkg::side_t side_s [NST];

	assign adv       = !valid_s[NST-1] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = valid_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			for (int i = 1; i < NST; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// finalize colour map, done up front and carried along
	// ------------------------------------------------------------------
	logic [16:0] inv_p;
	logic [24:0] cb_m;
	logic [23:0] cr_m;
	logic [15:0] dev;
	logic [18:0] dev10;
	logic [17:0] gnum;
	logic [25:0] gm_m;
	logic [17:0] g10_m;
	logic [7:0]  cb, cg, cr;
	logic        fin;

	always_comb begin
		inv_p = 17'h10000 - 17'(prior_value);
		cb_m  = 25'(inv_p) * 25'd255;
		cr_m  = 24'(prior_value) * 24'd255;
		cb    = cb_m[23:16];
		cr    = cr_m[23:16];
		// distance from mid scale, green peaks at 0.5 and is 0.3 high
		dev   = prior_value[15] ? prior_value - 16'h8000 : 16'h8000 - prior_value;
		dev10 = 19'(dev) * 19'd10;
		gnum  = 18'(19'd196608 - dev10);
		gm_m  = 26'(gnum) * 26'd255;
		// divide by ten through the reciprocal, exact below 1029
		g10_m = 18'(gm_m[25:16]) * 18'd205;
		cg    = (dev10 < 19'd196608) ? 8'(g10_m[17:11]) : 8'd0;
		fin   = (command == sghm_pkg::CMD_FINALIZE);

		side_in.cmd   = command;
		side_in.prior = prior_value;
		side_in.blue  = fin ? ({1'b0, blue_in[7:1]} + {1'b0, cb[7:1]}) : blue_in;
		side_in.green = fin ? ({1'b0, green_in[7:1]} + {1'b0, cg[7:1]}) : green_in;
		side_in.red   = fin ? ({1'b0, red_in[7:1]} + {1'b0, cr[7:1]}) : red_in;
	end

	// ------------------------------------------------------------------
	// stage 1: coordinate differences
	// ------------------------------------------------------------------
	logic signed [SW-1:0] ax_s1, ay_s1, bx_s1, by_s1, lx_s1, ly_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= $signed({1'b0, pixel_col}) - $signed({1'b0, sx_q});
			ay_s1 <= $signed({1'b0, pixel_row}) - $signed({1'b0, sy_q});
			bx_s1 <= $signed({1'b0, pixel_col}) - $signed({1'b0, ex_q});
			by_s1 <= $signed({1'b0, pixel_row}) - $signed({1'b0, ey_q});
			lx_s1 <= $signed({1'b0, ex_q}) - $signed({1'b0, sx_q});
			ly_s1 <= $signed({1'b0, ey_q}) - $signed({1'b0, sy_q});
		end
	end

	// ------------------------------------------------------------------
	// stage 2: squares and cross products
	// ------------------------------------------------------------------
	logic signed [PW-1:0] axx_s2, ayy_s2, bxx_s2, byy_s2, lxx_s2, lyy_s2, cp1_s2, cp2_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			axx_s2 <= PW'(ax_s1) * PW'(ax_s1);
			ayy_s2 <= PW'(ay_s1) * PW'(ay_s1);
			bxx_s2 <= PW'(bx_s1) * PW'(bx_s1);
			byy_s2 <= PW'(by_s1) * PW'(by_s1);
			lxx_s2 <= PW'(lx_s1) * PW'(lx_s1);
			lyy_s2 <= PW'(ly_s1) * PW'(ly_s1);
			cp1_s2 <= PW'(lx_s1) * PW'(ay_s1);
			cp2_s2 <= PW'(ly_s1) * PW'(ax_s1);
		end
	end

	// ------------------------------------------------------------------
	// stage 3: squared lengths and the cross product
	// ------------------------------------------------------------------
	logic [DSW-1:0]       d1_s3, d2_s3, len_s3;
	logic signed [PW-1:0] cross_s3;
	logic signed [PW-1:0] d1_sum, d2_sum, len_sum;

	assign d1_sum  = axx_s2 + ayy_s2;
	assign d2_sum  = bxx_s2 + byy_s2;
	assign len_sum = lxx_s2 + lyy_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s3    <= d1_sum[DSW-1:0];
			d2_s3    <= d2_sum[DSW-1:0];
			len_s3   <= len_sum[DSW-1:0];
			cross_s3 <= cp1_s2 - cp2_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: endpoint test, cross squared, divider load
	// divider: one quotient bit per stage, QB stages
	// ------------------------------------------------------------------
	logic [NW-1:0]  rem_sd  [QB+1];
	logic [QB-1:0]  quo_sd  [QB+1];
	logic [DSW-1:0] len_sd  [QB+1];
	logic [DSW-1:0] dend_sd [QB+1];
	logic           sel_sd  [QB+1];
	logic           lz_sd   [QB+1];

	logic [DSW:0]    d1_ext, d2_ext, d1_len, d2_len;
	logic [DSW-1:0]  cabs;
	logic [PW-1:0]   cneg;
	logic [C2W-1:0]  c2;
	logic            near_end, near_start;

	always_comb begin
		d1_ext     = (DSW+1)'(d1_s3);
		d2_ext     = (DSW+1)'(d2_s3);
		d1_len     = d1_ext + (DSW+1)'(len_s3);
		d2_len     = d2_ext + (DSW+1)'(len_s3);
		near_end   = d2_len < d1_ext;
		near_start = d1_len < d2_ext;
		cneg       = PW'(-cross_s3);
		cabs       = cross_s3[PW-1] ? cneg[DSW-1:0] : cross_s3[DSW-1:0];
		c2         = C2W'(cabs) * C2W'(cabs);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sd[0]  <= {c2, 8'd0};
			quo_sd[0]  <= '0;
			len_sd[0]  <= len_s3;
			dend_sd[0] <= near_end ? d2_s3 : d1_s3;
			sel_sd[0]  <= near_end || near_start;
			lz_sd[0]   <= (len_s3 == '0);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = QB - 1 - k;
		logic [NW-1:0] dsh;
		logic          take;

		assign dsh  = NW'(len_sd[k]) << SH;
		assign take = rem_sd[k] >= dsh;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sd[k+1]  <= take ? rem_sd[k] - dsh : rem_sd[k];
				quo_sd[k+1]  <= {quo_sd[k][QB-2:0], take};
				len_sd[k+1]  <= len_sd[k];
				dend_sd[k+1] <= dend_sd[k];
				sel_sd[k+1]  <= sel_sd[k];
				lz_sd[k+1]   <= lz_sd[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// distance pick and exponent t = decay * d^2, Q.32
	// ------------------------------------------------------------------
	logic [QB-1:0] dsel;
	logic [TW-1:0] t_sm;

	always_comb begin
		if (sel_sd[QB]) begin
			dsel = {dend_sd[QB], 8'd0};
		end else if (lz_sd[QB]) begin
			dsel = '0;   // zero-length segment
		end else begin
			dsel = quo_sd[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_sm <= TW'(decay_q) * TW'(dsel);
		end
	end

	// ------------------------------------------------------------------
	// series of exp(-t/32), three stages per term:
	// multiply by f, multiply by reciprocal of k, correct the quotient
	// ------------------------------------------------------------------
	logic [31:0] term_st [NT+1];
	logic [33:0] pos_st  [NT+1];
	logic [33:0] neg_st  [NT+1];
	logic [30:0] f_st    [NT+1];
	logic        z_st    [NT+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			z_st[0]    <= t_sm >= T_LIMIT;
			f_st[0]    <= t_sm[36:6];
			term_st[0] <= sghm_pkg::ONE_Q31;
			pos_st[0]  <= 34'(sghm_pkg::ONE_Q31);
			neg_st[0]  <= '0;
		end
	end

	for (genvar j = 0; j < NT; j++) begin : g_term
		localparam int  K   = j + 1;
		localparam bit  ODD = (K % 2) == 1;
		logic [62:0] prod_sa, mm_sb;
		logic [30:0] x_sb, f_sa, f_sb;
		logic [33:0] pos_sa, pos_sb, neg_sa, neg_sb;
		logic        z_sa, z_sb;
		logic [30:0] q0;
		logic [34:0] rr;
		logic [31:0] tn;

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_sa <= 63'(term_st[j]) * 63'(f_st[j]);
				f_sa    <= f_st[j];
				pos_sa  <= pos_st[j];
				neg_sa  <= neg_st[j];
				z_sa    <= z_st[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_sb   <= prod_sa[61:31];
				mm_sb  <= 63'(prod_sa[61:31]) * 63'(sghm_pkg::RECIP_Q32[j]);
				f_sb   <= f_sa;
				pos_sb <= pos_sa;
				neg_sb <= neg_sa;
				z_sb   <= z_sa;
			end
		end

		// estimate is the true quotient or one below
		always_comb begin
			q0 = mm_sb[62:32];
			rr = 35'(x_sb) - 35'(q0) * 35'(K);
			tn = 32'(q0) + 32'(rr >= 35'(K));
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				term_st[j+1] <= tn;
				f_st[j+1]    <= f_sb;
				z_st[j+1]    <= z_sb;
				pos_st[j+1]  <= ODD ? pos_sb : pos_sb + 34'(tn);
				neg_st[j+1]  <= ODD ? neg_sb + 34'(tn) : neg_sb;
			end
		end
	end

	// ------------------------------------------------------------------
	// clamp the series, then square five times
	// ------------------------------------------------------------------
	logic [31:0] e_sq [NSQ+1];
	logic        z_sq [NSQ+1];
	logic [33:0] e_diff;

	always_comb begin
		if (pos_st[NT] <= neg_st[NT]) begin
			e_diff = '0;
		end else begin
			e_diff = pos_st[NT] - neg_st[NT];
		end
		if (e_diff > 34'(sghm_pkg::ONE_Q31)) begin
			e_diff = 34'(sghm_pkg::ONE_Q31);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_sq[0] <= e_diff[31:0];
			z_sq[0] <= z_st[NT];
		end
	end

	for (genvar s = 0; s < NSQ; s++) begin : g_sq
		logic [63:0] e2;
		assign e2 = 64'(e_sq[s]) * 64'(e_sq[s]);

		always_ff @(posedge clk) begin
			if (adv) begin
				e_sq[s+1] <= e2[62:31];
				z_sq[s+1] <= z_sq[s];
			end
		end
	end

	// ------------------------------------------------------------------
	// peak weight with rounding, then max against the prior value (prior value alone on finalize)
	// ------------------------------------------------------------------
	logic [47:0] gprod;
	logic [15:0] gauss_sg;
	logic [15:0] newv_so;
	logic [15:0] prior_g;

	assign gprod   = 48'(peak_q) * 48'(e_sq[NSQ]) + 48'(sghm_pkg::HALF_Q31);
	assign prior_g = side_s[NST-2].prior;

	always_ff @(posedge clk) begin
		if (adv) begin
			gauss_sg <= z_sq[NSQ] ? 16'd0 : gprod[46:31];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s[NST-2].cmd == sghm_pkg::CMD_FINALIZE) begin
				newv_so <= prior_g;
			end else begin
				newv_so <= (gauss_sg > prior_g) ? gauss_sg : prior_g;
			end
		end
	end

	assign new_value = newv_so;
	assign blue_out  = side_s[NST-1].blue;
	assign green_out = side_s[NST-1].green;
	assign red_out   = side_s[NST-1].red;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`SGHM_ASSERT_IMP(a_div_rem, valid_s[DIVV] && !sel_sd[QB] && !lz_sd[QB], rem_sd[QB] < NW'(len_sd[QB]))
	`SGHM_ASSERT_IMP(a_exp_range, valid_s[SQV], e_sq[NSQ] <= sghm_pkg::ONE_Q31)
	`SGHM_ASSERT_IMP(a_accum_max, out_valid && side_s[NST-1].cmd == sghm_pkg::CMD_ACCUM, new_value >= side_s[NST-1].prior)
	`SGHM_ASSERT_NXT(a_div_hold, valid_s[DIVV] && !adv, $stable(quo_sd[QB]))

endmodule
